/* design/bosh_pkg.sv */
// Shared types, constants and the capacity decode for the signature hunter.
`timescale 1ns / 1ps
package bosh_pkg;

   // Buffer geometry
   localparam int BUFFER_BYTES = 4096;
   localparam int BUF_BITS     = BUFFER_BYTES * 8;
   localparam int CNT_RAW_W    = $clog2(BUF_BITS + 1);
   localparam int CNT_W        = (CNT_RAW_W > 16) ? CNT_RAW_W : 16;

   // Field widths
   localparam int BYTE_W  = 8;
   localparam int SIG_W   = 16;
   localparam int WIN_W   = 32;
   localparam int DATA_W  = WIN_W + BYTE_W;
   localparam int PAD_W   = DATA_W + 24;
   localparam int MASK_W  = 16;
   localparam int SEL_W   = $clog2(MASK_W);
   localparam int K_W     = 6;
   localparam int OFF_W   = 15;
   localparam int MIB_W   = 5;
   localparam int TOTAL_W = 15;

   // First shift (now - offset) that a candidate may sit at
   localparam int K_BASE = 16;
   // Candidates below this mask index still wait for ID bits
   localparam int PEND_N = 8;

   // Job queue depth
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Constants
   localparam logic [SIG_W-1:0]  SIG_RESET = 16'h0D5D;
   localparam logic [BYTE_W-1:0] ODD_ID    = 8'h26;
   localparam logic [2:0] TOP_16M  = 3'd4;
   localparam logic [2:0] TOP_8M_A = 3'd2;
   localparam logic [2:0] TOP_8M_B = 3'd3;
   localparam logic [2:0] TOP_4M   = 3'd1;
   localparam logic [MIB_W-1:0] MIB_16 = 5'd16;
   localparam logic [MIB_W-1:0] MIB_8  = 5'd8;
   localparam logic [MIB_W-1:0] MIB_4  = 5'd4;
   localparam logic [MIB_W-1:0] MIB_2  = 5'd2;

   // One classified request handed from front to back
   typedef struct packed {
      logic [MASK_W-1:0] mask;   // bit j: hit at shift j + K_BASE
      logic [DATA_W-1:0] data;   // window plus new byte, newest bit at 0
      logic [CNT_W-1:0]  now;    // bits seen including this byte
      logic              last;   // closes the buffer
   } job_type;

   // One response word
   typedef struct packed {
      logic [OFF_W-1:0]   bit_offset;
      logic [BYTE_W-1:0]  id_byte;
      logic [MIB_W-1:0]   size_mib;
      logic               is_summary;
      logic [TOTAL_W-1:0] hit_total;
      logic               end_of_run;
   } rsp_type;

   // Size ladder from the ID byte
   function automatic logic [MIB_W-1:0] capacity_of(input logic [BYTE_W-1:0] id);
      logic [2:0] top;
      top = id[7:5];
      if (top == TOP_16M) return MIB_16;
      if (id == ODD_ID || top == TOP_8M_A || top == TOP_8M_B) return MIB_8;
      if (top == TOP_4M) return MIB_4;
      return MIB_2;
   endfunction

endpackage

/* design/bosh_front.sv */
// Front end: bit window, signature register and parallel offset compare.
`timescale 1ns / 1ps
module bosh_front
   import bosh_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_accept,
   input  logic [BYTE_W-1:0] req_data_byte,
   input  logic              req_last_byte,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [SIG_W-1:0]  csr_signature,
   output logic              job_push,
   output job_type           job
);

   logic [WIN_W-1:0] window_ff, window_in;
   logic [CNT_W-1:0] seen_ff, seen_in;
   logic [SIG_W-1:0] sig_ff;

   logic [DATA_W-1:0] w;
   logic [PAD_W-1:0]  p;
   logic [CNT_W-1:0]  now;
   logic              last;
   logic [MASK_W-1:0] mask;

   assign csr_ready = 1'b1;

   // Compare all sixteen candidate shifts at once
   always_comb begin
      w    = {window_ff, req_data_byte};
      p    = {w, 24'b0};
      now  = seen_ff + CNT_W'(BYTE_W);
      last = req_last_byte || (now >= CNT_W'(BUF_BITS));
      for (int i = 0; i < MASK_W; i++) begin
         mask[i] = (p[i + K_BASE + 8 +: SIG_W] == sig_ff)
                   && (CNT_W'(i + K_BASE) <= now)
                   && (i >= PEND_N || last);
      end
   end

   // Only requests that produce a response go to the back end
   assign job_push = req_accept && ((mask != '0) || last);
   assign job      = '{mask: mask, data: w, now: now, last: last};

   // Next window state
   always_comb begin
      window_in = window_ff;
      seen_in   = seen_ff;
      if (req_accept) begin
         if (last) begin
            window_in = '0;
            seen_in   = '0;
         end else begin
            window_in = w[WIN_W-1:0];
            seen_in   = now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         seen_ff   <= '0;
         sig_ff    <= SIG_RESET;
      end else begin
         window_ff <= window_in;
         seen_ff   <= seen_in;
         if (csr_valid && csr_ready) sig_ff <= csr_signature;
      end
   end

endmodule

/* design/bosh_queue.sv */
// Short job queue between front and back end.
`timescale 1ns / 1ps
module bosh_queue
   import bosh_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_en,
   input  job_type push_job,
   output logic    q_full,
   input  logic    pop_en,
   output logic    head_valid,
   output job_type head_job
);

   job_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ff, rd_ff;
   logic [QCNT_W-1:0] cnt_ff;
   logic              do_push, do_pop;

   assign q_full     = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_job   = slot_ff[rd_ff];
   assign do_push    = push_en && !q_full;
   assign do_pop     = pop_en && head_valid;

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) wr_ff <= (wr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         if (do_pop)  rd_ff <= (rd_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         if (do_push && !do_pop)      cnt_ff <= cnt_ff + 1'b1;
         else if (do_pop && !do_push) cnt_ff <= cnt_ff - 1'b1;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ff] <= push_job;
   end

endmodule

/* design/bosh_back.sv */
// Back end: walks each job's hit mask and drives the response register.
`timescale 1ns / 1ps
module bosh_back
   import bosh_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    head_valid,
   input  job_type head_job,
   output logic    head_pop,
   input  logic    rsp_pop,
   output logic    rsp_valid,
   output rsp_type rsp
);

   logic [MASK_W-1:0]  done_ff, done_in;
   logic [TOTAL_W-1:0] cnt_ff, cnt_in;
   logic               valid_ff;
   rsp_type            rsp_ff, rsp_in;

   logic [MASK_W-1:0] cur, rest, sel_bit;
   logic [SEL_W-1:0]  sel;
   logic [K_W-1:0]    k;
   logic [PAD_W-1:0]  p;
   logic [BYTE_W-1:0] id;
   logic [CNT_W-1:0]  off;
   logic              step;

   // Pick the largest pending shift, which is the earliest offset
   always_comb begin
      cur = head_job.mask & ~done_ff;
      sel = '0;
      for (int i = 0; i < MASK_W; i++) begin
         if (cur[i]) sel = SEL_W'(i);
      end
      sel_bit = MASK_W'(1) << sel;
      rest    = cur & ~sel_bit;
      k       = K_W'(sel) + K_W'(K_BASE);
      p       = {head_job.data, 24'b0};
      id      = p[k +: BYTE_W];
      off     = head_job.now - CNT_W'(k);
   end

   assign step = head_valid && (!valid_ff || rsp_pop);

   // Build one response per step
   always_comb begin
      rsp_in   = rsp_ff;
      done_in  = done_ff;
      cnt_in   = cnt_ff;
      head_pop = 1'b0;
      if (step) begin
         if (cur != '0) begin
            rsp_in.bit_offset = off[OFF_W-1:0];
            rsp_in.id_byte    = id;
            rsp_in.size_mib   = capacity_of(id);
            rsp_in.is_summary = 1'b0;
            rsp_in.hit_total  = '0;
            rsp_in.end_of_run = (rest == '0) && !head_job.last;
            cnt_in            = cnt_ff + 1'b1;
            if ((rest == '0) && !head_job.last) begin
               head_pop = 1'b1;
               done_in  = '0;
            end else begin
               done_in = done_ff | sel_bit;
            end
         end else begin
            // mask exhausted on a closing job: summary
            rsp_in.bit_offset = '0;
            rsp_in.id_byte    = '0;
            rsp_in.size_mib   = '0;
            rsp_in.is_summary = 1'b1;
            rsp_in.hit_total  = cnt_ff;
            rsp_in.end_of_run = 1'b1;
            cnt_in            = '0;
            done_in           = '0;
            head_pop          = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         done_ff  <= '0;
         cnt_ff   <= '0;
      end else begin
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
         if (step)         valid_ff <= 1'b1;
         else if (rsp_pop) valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;

endmodule

/* design/bit_offset_signature_hunter_core.sv */
// Top level of the bit offset signature hunter.
//
//   channel   ports                                 handshake
//   request   req_data_byte, req_last_byte          push / full
//   response  rsp_bit_offset .. rsp_end_of_run      empty / pop
//   config    csr_signature                         csr_valid / csr_ready
//
// A request is taken every cycle while the four-entry job queue has room.
// The back end sends one response per cycle while responses are popped: a
// request with n hits gives n responses, plus a summary on the closing
// byte; requests with no hit and no buffer end never enter the queue.
// Reset is synchronous; it clears the window, counts, queue and response
// valid flag and loads the signature with 0x0D5D. csr_ready is always high.
`timescale 1ns / 1ps
module bit_offset_signature_hunter_core
   import bosh_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [BYTE_W-1:0]  req_data_byte,
   input  logic               req_last_byte,
   output logic               empty,
   input  logic               pop,
   output logic [OFF_W-1:0]   rsp_bit_offset,
   output logic [BYTE_W-1:0]  rsp_id_byte,
   output logic [MIB_W-1:0]   rsp_size_mib,
   output logic               rsp_is_summary,
   output logic [TOTAL_W-1:0] rsp_hit_total,
   output logic               rsp_end_of_run,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [SIG_W-1:0]   csr_signature
);

   logic    req_accept, job_push, q_full, head_valid, head_pop, rsp_valid;
   job_type job, head_job;
   rsp_type rsp;

   assign full       = q_full;
   assign req_accept = push && !q_full;

   bosh_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_accept    (req_accept),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_signature (csr_signature),
      .job_push      (job_push),
      .job           (job)
   );

   bosh_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_en    (job_push),
      .push_job   (job),
      .q_full     (q_full),
      .pop_en     (head_pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   bosh_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .head_pop   (head_pop),
      .rsp_pop    (pop),
      .rsp_valid  (rsp_valid),
      .rsp        (rsp)
   );

   // Response ports
   assign empty          = !rsp_valid;
   assign rsp_bit_offset = rsp.bit_offset;
   assign rsp_id_byte    = rsp.id_byte;
   assign rsp_size_mib   = rsp.size_mib;
   assign rsp_is_summary = rsp.is_summary;
   assign rsp_hit_total  = rsp.hit_total;
   assign rsp_end_of_run = rsp.end_of_run;

endmodule
